// ----- hdl/gtp_pkg.sv -----
`timescale 1ns / 1ps

package gtp_pkg;

  // Field and register widths
  localparam int RATE_W    = 16;
  localparam int BIAS_W    = 25;
  localparam int SMOOTH_W  = 26;
  localparam int ACC_W     = 28;
  localparam int FRAC_W    = 16;
  localparam int WHOLE_W   = ACC_W - FRAC_W;
  localparam int MOVE_W    = 8;
  localparam int ALPHA_W   = 9;
  localparam int DB_W      = 23;
  localparam int GAIN_W    = 17;
  localparam int CC_W      = 11;
  localparam int CFG_W     = 23;
  localparam int CFG_IDX_W = 2;
  localparam int Q8_SH     = 8;
  localparam int PROD_W    = SMOOTH_W + GAIN_W;

  localparam int MAX_CAL_SAMPLES_DEF = 1024;
  localparam int MOVE_LIM            = 127;

  localparam logic [ALPHA_W-1:0]       ALPHA_ONE = ALPHA_W'(256);
  localparam logic [ALPHA_W-1:0]       ALPHA_RST = ALPHA_W'(77);
  localparam logic [DB_W-1:0]          DB_RST    = DB_W'(3354);
  localparam logic signed [GAIN_W-1:0] GAIN_RST  = -GAIN_W'(1001);
  localparam logic [CC_W-1:0]          CC_RST    = CC_W'(150);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EMA_ALPHA   = 2'd0,
    REG_DEAD_BAND   = 2'd1,
    REG_MOTION_GAIN = 2'd2,
    REG_CAL_COUNT   = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    T_IDLE,
    T_BIAS_Y,
    T_BIAS_Z,
    T_RUN,
    T_EMIT
  } top_st_t;

  typedef enum logic [2:0] {
    L_IDLE,
    L_MUL1,
    L_RND1,
    L_GATE,
    L_MUL2,
    L_RND2,
    L_ACC
  } lane_st_t;

  typedef enum logic [1:0] {
    D_IDLE,
    D_PREP,
    D_RUN,
    D_FIX
  } div_st_t;

  typedef struct packed {
    logic [ALPHA_W-1:0]       alpha;
    logic [DB_W-1:0]          dead_band;
    logic signed [GAIN_W-1:0] gain;
  } lane_cfg_t;

  typedef struct packed {
    logic start;
    logic commit;
  } lane_ctl_t;

  typedef struct packed {
    logic                      done;
    logic signed [WHOLE_W-1:0] whole;
  } lane_sts_t;

endpackage

// ----- hdl/gtp_in_if.sv -----
`timescale 1ns / 1ps

interface gtp_in_if;
  import gtp_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     link_up;
  logic signed [RATE_W-1:0] rate_y;
  logic signed [RATE_W-1:0] rate_z;

  modport source (output valid, link_up, rate_y, rate_z, input ready);
  modport sink   (input valid, link_up, rate_y, rate_z, output ready);
endinterface

// ----- hdl/gtp_out_if.sv -----
`timescale 1ns / 1ps

interface gtp_out_if;
  import gtp_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [MOVE_W-1:0] move_x;
  logic signed [MOVE_W-1:0] move_y;

  modport source (output valid, move_x, move_y, input ready);
  modport sink   (input valid, move_x, move_y, output ready);
endinterface

// ----- hdl/gtp_div.sv -----
`timescale 1ns / 1ps

// Restoring divider, one quotient bit a cycle: round(num * 256 / den), ties away from zero.
module gtp_div #(
  parameter int NUM_W = 27,
  parameter int DEN_W = 11
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic signed [NUM_W-1:0]          num,
  input  logic [DEN_W-1:0]                 den,
  output logic                             done,
  output logic signed [gtp_pkg::BIAS_W-1:0] quot
);
  import gtp_pkg::*;

  localparam int DVD_W = NUM_W + Q8_SH + 1;
  localparam int IT_W  = $clog2(DVD_W);

  div_st_t                  st_r, st_nxt;
  logic [DVD_W-1:0]         dvd_r, dvd_nxt;
  logic [DEN_W-1:0]         rem_r, rem_nxt;
  logic [DEN_W-1:0]         den_r, den_nxt;
  logic                     neg_r, neg_nxt;
  logic [IT_W-1:0]          it_r, it_nxt;
  logic signed [BIAS_W-1:0] quot_r, quot_nxt;
  logic                     done_r, done_nxt;

  logic [NUM_W-1:0] mag;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_sub;
  logic             ge;

  always_comb begin
    mag     = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    rem_sh  = {rem_r, dvd_r[DVD_W-1]};
    rem_sub = rem_sh - {1'b0, den_r};
    ge      = (rem_sh >= {1'b0, den_r});
  end

  always_comb begin
    st_nxt   = st_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    it_nxt   = it_r;
    quot_nxt = quot_r;
    done_nxt = 1'b0;
    case (st_r)
      D_IDLE: begin
        if (start) begin
          neg_nxt = num[NUM_W-1];
          dvd_nxt = {1'b0, mag, {Q8_SH{1'b0}}};
          den_nxt = den;
          rem_nxt = '0;
          it_nxt  = '0;
          st_nxt  = D_PREP;
        end
      end
      D_PREP: begin
        // add half the divisor for rounding
        dvd_nxt = dvd_r + DVD_W'(den_r >> 1);
        st_nxt  = D_RUN;
      end
      D_RUN: begin
        rem_nxt = ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        dvd_nxt = {dvd_r[DVD_W-2:0], ge};
        it_nxt  = it_r + 1'b1;
        if (it_r == IT_W'(DVD_W - 1)) begin
          st_nxt = D_FIX;
        end
      end
      D_FIX: begin
        quot_nxt = neg_r ? -dvd_r[BIAS_W-1:0] : dvd_r[BIAS_W-1:0];
        done_nxt = 1'b1;
        st_nxt   = D_IDLE;
      end
      default: begin
        st_nxt = D_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= D_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r  <= dvd_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    neg_r  <= neg_nxt;
    it_r   <= it_nxt;
    quot_r <= quot_nxt;
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

// ----- hdl/gtp_lane.sv -----
`timescale 1ns / 1ps

// One axis: EMA, deadzone and gain, each product formed by serial shift-and-add
// over the multiplier bits, then the saturating pixel accumulator.
module gtp_lane (
  input  logic                              clk,
  input  logic                              rst_n,
  input  gtp_pkg::lane_cfg_t                cfg,
  input  gtp_pkg::lane_ctl_t                ctl,
  input  logic signed [gtp_pkg::RATE_W-1:0] rate,
  input  logic signed [gtp_pkg::BIAS_W-1:0] bias,
  output gtp_pkg::lane_sts_t                sts
);
  import gtp_pkg::*;

  localparam int CNT_W = $clog2(GAIN_W);
  localparam logic signed [PROD_W-1:0] RND_UP = PROD_W'(1 << (Q8_SH - 1));
  localparam logic signed [PROD_W-1:0] RND_DN = PROD_W'((1 << (Q8_SH - 1)) - 1);
  localparam logic signed [PROD_W-1:0] ACC_HI = PROD_W'((1 << (ACC_W - 1)) - 1);
  localparam logic signed [PROD_W-1:0] ACC_LO = ~ACC_HI;

  lane_st_t                   st_r, st_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic [GAIN_W-1:0]          mr_r, mr_nxt;
  logic [ALPHA_W-1:0]         mb_r, mb_nxt;
  logic signed [PROD_W-1:0]   xa_r, xa_nxt;
  logic signed [PROD_W-1:0]   xb_r, xb_nxt;
  logic signed [PROD_W-1:0]   p_r, p_nxt;
  logic signed [SMOOTH_W-1:0] smooth_r, smooth_nxt;
  logic signed [ACC_W-1:0]    accum_r, accum_nxt;
  logic                       done_r, done_nxt;

  logic [ALPHA_W-1:0]         alpha_c;
  logic signed [SMOOTH_W-1:0] cur;
  logic signed [PROD_W-1:0]   p_rnd;
  logic [SMOOTH_W-1:0]        mag;
  logic                       pass;
  logic signed [PROD_W-1:0]   acc_sum;
  logic                       neg_frac;
  logic signed [WHOLE_W-1:0]  whole;
  logic signed [ACC_W-1:0]    rem;

  always_comb begin
    alpha_c  = (cfg.alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.alpha;
    cur      = $signed({{(SMOOTH_W - RATE_W - Q8_SH){rate[RATE_W-1]}}, rate, {Q8_SH{1'b0}}})
               - SMOOTH_W'(bias);
    // round half away from zero on a divide by 256
    p_rnd    = p_r + (p_r[PROD_W-1] ? RND_DN : RND_UP);
    mag      = smooth_r[SMOOTH_W-1] ? SMOOTH_W'(-smooth_r) : SMOOTH_W'(smooth_r);
    pass     = (mag > SMOOTH_W'(cfg.dead_band));
    acc_sum  = PROD_W'(accum_r) + p_r;
    neg_frac = accum_r[ACC_W-1] && (|accum_r[FRAC_W-1:0]);
    whole    = accum_r[ACC_W-1:FRAC_W] + {{(WHOLE_W - 1){1'b0}}, neg_frac};
    rem      = neg_frac ? {{WHOLE_W{1'b1}}, accum_r[FRAC_W-1:0]}
                        : {{WHOLE_W{1'b0}}, accum_r[FRAC_W-1:0]};
  end

  always_comb begin
    st_nxt     = st_r;
    cnt_nxt    = cnt_r;
    mr_nxt     = mr_r;
    mb_nxt     = mb_r;
    xa_nxt     = xa_r;
    xb_nxt     = xb_r;
    p_nxt      = p_r;
    smooth_nxt = smooth_r;
    accum_nxt  = accum_r;
    done_nxt   = 1'b0;
    case (st_r)
      L_IDLE: begin
        if (ctl.start) begin
          xa_nxt  = PROD_W'(cur);
          xb_nxt  = PROD_W'(smooth_r);
          mr_nxt  = GAIN_W'(alpha_c);
          mb_nxt  = ALPHA_ONE - alpha_c;
          p_nxt   = '0;
          cnt_nxt = '0;
          st_nxt  = L_MUL1;
        end else if (ctl.commit) begin
          accum_nxt = rem;
        end
      end
      L_MUL1: begin
        p_nxt   = p_r + (mr_r[0] ? xa_r : '0) + (mb_r[0] ? xb_r : '0);
        xa_nxt  = xa_r <<< 1;
        xb_nxt  = xb_r <<< 1;
        mr_nxt  = mr_r >> 1;
        mb_nxt  = mb_r >> 1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(ALPHA_W - 1)) begin
          st_nxt = L_RND1;
        end
      end
      L_RND1: begin
        smooth_nxt = p_rnd[SMOOTH_W+Q8_SH-1:Q8_SH];
        st_nxt     = L_GATE;
      end
      L_GATE: begin
        xa_nxt  = pass ? PROD_W'(smooth_r) : '0;
        mr_nxt  = cfg.gain;
        p_nxt   = '0;
        cnt_nxt = '0;
        st_nxt  = L_MUL2;
      end
      L_MUL2: begin
        // top gain bit carries negative weight
        if (mr_r[0]) begin
          if (cnt_r == CNT_W'(GAIN_W - 1)) begin
            p_nxt = p_r - xa_r;
          end else begin
            p_nxt = p_r + xa_r;
          end
        end
        xa_nxt  = xa_r <<< 1;
        mr_nxt  = mr_r >> 1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(GAIN_W - 1)) begin
          st_nxt = L_RND2;
        end
      end
      L_RND2: begin
        p_nxt  = p_rnd >>> Q8_SH;
        st_nxt = L_ACC;
      end
      L_ACC: begin
        if (acc_sum > ACC_HI) begin
          accum_nxt = ACC_HI[ACC_W-1:0];
        end else if (acc_sum < ACC_LO) begin
          accum_nxt = ACC_LO[ACC_W-1:0];
        end else begin
          accum_nxt = acc_sum[ACC_W-1:0];
        end
        done_nxt = 1'b1;
        st_nxt   = L_IDLE;
      end
      default: begin
        st_nxt = L_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= L_IDLE;
      done_r   <= 1'b0;
      smooth_r <= '0;
      accum_r  <= '0;
    end else begin
      st_r     <= st_nxt;
      done_r   <= done_nxt;
      smooth_r <= smooth_nxt;
      accum_r  <= accum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    mr_r  <= mr_nxt;
    mb_r  <= mb_nxt;
    xa_r  <= xa_nxt;
    xb_r  <= xb_nxt;
    p_r   <= p_nxt;
  end

  assign sts.done  = done_r;
  assign sts.whole = whole;

endmodule

// ----- hdl/gyro_to_pointer_motion.sv -----
`timescale 1ns / 1ps

// Gyro rate samples in, pointer moves out.
// in_ch carries one item per sample: link_up plus signed Y and Z rates. out_ch
// carries move_x (from Z) and move_y (from Y), each saturated to +-127.
// cfg_we / cfg_index / cfg_data write ema_alpha, dead_band, motion_gain and
// calibration_count; write them only while the block is idle.
// A link-down item or a calibration sample leaves the block idle. The sample
// that completes calibration runs the serial divider twice, once per axis,
// Y then Z. A filtered item runs the two serial multiplies in each axis lane
// (9 alpha bits, then 17 gain bits), then rounds and accumulates; both lanes
// run side by side. A move is then handed to the output register on out_ch.
// No item is taken until the block is back in its idle state.
// Reset clears configuration to its defaults, calibration, bias, filter and
// accumulators, and drops any pending move.
// A stalled receiver does not stop intake at first: the register holds its item
// and the next is taken; a new move waits, with intake, until the register frees.
module gyro_to_pointer_motion #(
  parameter int MAX_CAL_SAMPLES = gtp_pkg::MAX_CAL_SAMPLES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  gtp_in_if.sink                         in_ch,
  gtp_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [gtp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gtp_pkg::CFG_W-1:0]      cfg_data
);
  import gtp_pkg::*;

  localparam int CNT_W = $clog2(MAX_CAL_SAMPLES + 1);
  localparam int SUM_W = RATE_W + CNT_W;
  localparam int NW    = (CNT_W > CC_W) ? CNT_W : CC_W;
  localparam logic [NW-1:0] N_MAX = NW'(MAX_CAL_SAMPLES);
  localparam logic signed [WHOLE_W-1:0] W_HI = WHOLE_W'(MOVE_LIM);
  localparam logic signed [WHOLE_W-1:0] W_LO = -W_HI;

  // configuration registers
  logic [ALPHA_W-1:0]       alpha_r;
  logic [DB_W-1:0]          db_r;
  logic signed [GAIN_W-1:0] gain_r;
  logic [CC_W-1:0]          cc_r;

  // control and calibration state
  top_st_t                  st_r, st_nxt;
  logic                     cal_done_r, cal_done_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic signed [SUM_W-1:0]  sum_y_r, sum_y_nxt;
  logic signed [SUM_W-1:0]  sum_z_r, sum_z_nxt;
  logic signed [BIAS_W-1:0] bias_y_r, bias_y_nxt;
  logic signed [BIAS_W-1:0] bias_z_r, bias_z_nxt;

  // output register
  logic                     out_valid_r, out_valid_nxt;
  logic signed [MOVE_W-1:0] move_x_r, move_x_nxt;
  logic signed [MOVE_W-1:0] move_y_r, move_y_nxt;

  logic                     accept;
  logic signed [SUM_W-1:0]  sum_y_add, sum_z_add;
  logic [CNT_W-1:0]         cnt_inc;
  logic [NW-1:0]            cc_ext, n_eff;
  logic                     cal_full;

  logic                     div_start, div_done;
  logic signed [SUM_W-1:0]  div_num;
  logic [CNT_W-1:0]         div_den;
  logic signed [BIAS_W-1:0] div_quot;

  lane_cfg_t                lane_cfg;
  lane_ctl_t                lane_ctl;
  lane_sts_t                sts_x, sts_y;

  function automatic logic signed [MOVE_W-1:0] clip_move(logic signed [WHOLE_W-1:0] w);
    logic signed [WHOLE_W-1:0] c;
    c = (w > W_HI) ? W_HI : ((w < W_LO) ? W_LO : w);
    return c[MOVE_W-1:0];
  endfunction

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= ALPHA_RST;
      db_r    <= DB_RST;
      gain_r  <= GAIN_RST;
      cc_r    <= CC_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_EMA_ALPHA:   alpha_r <= cfg_data[ALPHA_W-1:0];
        REG_DEAD_BAND:   db_r    <= cfg_data[DB_W-1:0];
        REG_MOTION_GAIN: gain_r  <= cfg_data[GAIN_W-1:0];
        REG_CAL_COUNT:   cc_r    <= cfg_data[CC_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ch.ready = (st_r == T_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  // calibration bookkeeping: the effective count is clamped to 1..MAX_CAL_SAMPLES
  always_comb begin
    sum_y_add = sum_y_r + SUM_W'(in_ch.rate_y);
    sum_z_add = sum_z_r + SUM_W'(in_ch.rate_z);
    cnt_inc   = cnt_r + 1'b1;
    cc_ext    = NW'(cc_r);
    if (cc_ext == '0) begin
      n_eff = NW'(1);
    end else if (cc_ext > N_MAX) begin
      n_eff = N_MAX;
    end else begin
      n_eff = cc_ext;
    end
    cal_full = (NW'(cnt_inc) >= n_eff);
  end

  // Y bias starts straight from the accept cycle; Z follows from the stored sums
  assign div_num = (st_r == T_IDLE) ? sum_y_add : sum_z_r;
  assign div_den = (st_r == T_IDLE) ? cnt_inc : cnt_r;

  assign lane_cfg.alpha     = alpha_r;
  assign lane_cfg.dead_band = db_r;
  assign lane_cfg.gain      = gain_r;

  always_comb begin
    st_nxt          = st_r;
    cal_done_nxt    = cal_done_r;
    cnt_nxt         = cnt_r;
    sum_y_nxt       = sum_y_r;
    sum_z_nxt       = sum_z_r;
    bias_y_nxt      = bias_y_r;
    bias_z_nxt      = bias_z_r;
    move_x_nxt      = move_x_r;
    move_y_nxt      = move_y_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    div_start       = 1'b0;
    lane_ctl.start  = 1'b0;
    lane_ctl.commit = 1'b0;
    case (st_r)
      T_IDLE: begin
        if (accept) begin
          if (!in_ch.link_up) begin
            // link lost: drop calibration, keep filter, bias and accumulators
            cal_done_nxt = 1'b0;
            cnt_nxt      = '0;
            sum_y_nxt    = '0;
            sum_z_nxt    = '0;
          end else if (!cal_done_r) begin
            sum_y_nxt = sum_y_add;
            sum_z_nxt = sum_z_add;
            cnt_nxt   = cnt_inc;
            if (cal_full) begin
              div_start = 1'b1;
              st_nxt    = T_BIAS_Y;
            end
          end else begin
            lane_ctl.start = 1'b1;
            st_nxt         = T_RUN;
          end
        end
      end
      T_BIAS_Y: begin
        if (div_done) begin
          bias_y_nxt = div_quot;
          div_start  = 1'b1;
          st_nxt     = T_BIAS_Z;
        end
      end
      T_BIAS_Z: begin
        if (div_done) begin
          bias_z_nxt   = div_quot;
          cal_done_nxt = 1'b1;
          cnt_nxt      = '0;
          sum_y_nxt    = '0;
          sum_z_nxt    = '0;
          st_nxt       = T_IDLE;
        end
      end
      T_RUN: begin
        if (sts_y.done) begin
          st_nxt = ((sts_x.whole != '0) || (sts_y.whole != '0)) ? T_EMIT : T_IDLE;
        end
      end
      T_EMIT: begin
        // wait for the output register, then hand over and strip the whole pixels
        if (!out_valid_r || out_ch.ready) begin
          move_x_nxt      = clip_move(sts_x.whole);
          move_y_nxt      = clip_move(sts_y.whole);
          out_valid_nxt   = 1'b1;
          lane_ctl.commit = 1'b1;
          st_nxt          = T_IDLE;
        end
      end
      default: begin
        st_nxt = T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= T_IDLE;
      cal_done_r  <= 1'b0;
      cnt_r       <= '0;
      sum_y_r     <= '0;
      sum_z_r     <= '0;
      bias_y_r    <= '0;
      bias_z_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      cal_done_r  <= cal_done_nxt;
      cnt_r       <= cnt_nxt;
      sum_y_r     <= sum_y_nxt;
      sum_z_r     <= sum_z_nxt;
      bias_y_r    <= bias_y_nxt;
      bias_z_r    <= bias_z_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    move_x_r <= move_x_nxt;
    move_y_r <= move_y_nxt;
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.move_x = move_x_r;
  assign out_ch.move_y = move_y_r;

  // shared bias divider, Y then Z
  gtp_div #(
    .NUM_W (SUM_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Z rate drives horizontal motion
  gtp_lane u_lane_x (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (lane_cfg),
    .ctl   (lane_ctl),
    .rate  (in_ch.rate_z),
    .bias  (bias_z_r),
    .sts   (sts_x)
  );

  gtp_lane u_lane_y (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (lane_cfg),
    .ctl   (lane_ctl),
    .rate  (in_ch.rate_y),
    .bias  (bias_y_r),
    .sts   (sts_y)
  );

endmodule

// ----- tb/gyro_to_pointer_motion_tb.sv -----
`timescale 1ns / 1ps

module gyro_to_pointer_motion_tb;
  import gtp_pkg::*;

  localparam int     MAX_CAL       = MAX_CAL_SAMPLES_DEF;
  localparam int     SETTLE_CYCLES = 200;   // covers the two-axis bias divide
  localparam int     LONG_HOLD     = 600;
  localparam int     TOTAL_ITEMS   = 1200;
  localparam int     N_ROWS        = 39;
  localparam longint TIMEOUT_NS    = 20_000_000;
  localparam longint ACC_HI        = (longint'(1) << (ACC_W - 1)) - 1;
  localparam longint ACC_LO        = -(longint'(1) << (ACC_W - 1));

  typedef enum logic [1:0] {ROW_CFG, ROW_ITEM} row_kind_t;
  // the predictor sets the CHK_MODEL expectation; CHK_MOVE takes the move typed in the row, CHK_NONE owes none
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_MOVE} row_chk_t;

  typedef struct packed {
    logic signed [MOVE_W-1:0] x;
    logic signed [MOVE_W-1:0] y;
  } move_t;

  typedef struct packed {
    row_kind_t                kind;
    cfg_reg_t                 reg_sel;
    logic [CFG_W-1:0]         cfg_val;
    logic                     link;
    logic signed [RATE_W-1:0] ry;
    logic signed [RATE_W-1:0] rz;
    row_chk_t                 chk;
    move_t                    mv;
  } row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  gtp_in_if  in_ch ();
  gtp_out_if out_ch ();

  gyro_to_pointer_motion DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predictor copy of the configuration
  logic [ALPHA_W-1:0]       cur_alpha;
  logic [DB_W-1:0]          cur_band;
  logic signed [GAIN_W-1:0] cur_gain;
  logic [CC_W-1:0]          cur_cal_len;

  // Predictor state: calibration sums, per-axis offset (Q8), EMA (Q8),
  // fractional pixel accumulators (Q16); x is driven by Z, y by Y
  bit                         cal_done;
  logic [CC_W-1:0]            cal_seen;
  logic signed [26:0]         rate_sum_y, rate_sum_z;
  logic signed [BIAS_W-1:0]   offset_y, offset_z;
  logic signed [SMOOTH_W-1:0] ema_y, ema_z;
  logic signed [ACC_W-1:0]    frac_x, frac_y;

  move_t       move_q[$];      // moves still owed by the block, oldest first
  row_t        directed_rows [N_ROWS];
  int unsigned err_count  = 0;
  int unsigned moves_seen = 0;
  int unsigned items_sent = 0;
  int unsigned hold_at    = 40;
  int unsigned rx_stall   = 0;
  int unsigned rx_calm    = 0;
  int unsigned tx_calm    = 0;
  bit          input_dirty = 0;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Arithmetic of the pointer path
  // ---------------------------------------------------------------------------

  // Divide and round to nearest, ties away from zero; den is positive
  function automatic longint div_nearest(longint num, longint den);
    longint mag, q;
    mag = (num < 0) ? -num : num;
    q   = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // One axis: drop the offset, smooth, gate by the dead band, then scale the
  // survivor into the Q16 accumulator, saturating at the accumulator's range
  function automatic void step_axis(input longint rate, input longint offset,
                                    inout logic signed [SMOOTH_W-1:0] ema,
                                    inout logic signed [ACC_W-1:0] frac,
                                    input longint a, input longint g);
    longint cur, s, gated, acc;
    cur   = rate * 256 - offset;
    s     = div_nearest(a * cur + (256 - a) * longint'(ema), 256);
    ema   = SMOOTH_W'(s);
    gated = (((s < 0) ? -s : s) > longint'(cur_band)) ? s : 0;
    acc   = clamp(longint'(frac) + div_nearest(gated * g, 256), ACC_LO, ACC_HI);
    frac  = ACC_W'(acc);
  endfunction

  // Advance the predictor by one accepted item; return 1 when a move is due
  function automatic bit predict_move(input logic link,
                                      input logic signed [RATE_W-1:0] ry,
                                      input logic signed [RATE_W-1:0] rz,
                                      output move_t mv);
    longint need, a, tx, ty;
    mv = '0;
    if (!link) begin
      // link lost: forget calibration, keep offsets, filter and fractions
      cal_done   = 1'b0;
      cal_seen   = '0;
      rate_sum_y = '0;
      rate_sum_z = '0;
      return 1'b0;
    end
    if (!cal_done) begin
      // zero behaves as one, anything past the store's depth as the depth
      need = (cur_cal_len == 0) ? 1 : ((cur_cal_len > MAX_CAL) ? MAX_CAL : cur_cal_len);
      rate_sum_y = rate_sum_y + ry;
      rate_sum_z = rate_sum_z + rz;
      cal_seen   = cal_seen + 1'b1;
      if (cal_seen >= need) begin
        // divide by what was actually summed, not by the current count
        offset_y   = BIAS_W'(div_nearest(longint'(rate_sum_y) * 256, longint'(cal_seen)));
        offset_z   = BIAS_W'(div_nearest(longint'(rate_sum_z) * 256, longint'(cal_seen)));
        cal_done   = 1'b1;
        cal_seen   = '0;
        rate_sum_y = '0;
        rate_sum_z = '0;
      end
      return 1'b0;
    end
    a = (cur_alpha > ALPHA_ONE) ? ALPHA_ONE : cur_alpha;
    step_axis(rz, offset_z, ema_z, frac_x, a, cur_gain);
    step_axis(ry, offset_y, ema_y, frac_y, a, cur_gain);
    tx = longint'(frac_x) / 65536;
    ty = longint'(frac_y) / 65536;
    if (tx == 0 && ty == 0)
      return 1'b0;
    // take off the whole integer part; only the emitted step saturates
    frac_x = ACC_W'(longint'(frac_x) - tx * 65536);
    frac_y = ACC_W'(longint'(frac_y) - ty * 65536);
    mv.x   = MOVE_W'(clamp(tx, -MOVE_LIM, MOVE_LIM));
    mv.y   = MOVE_W'(clamp(ty, -MOVE_LIM, MOVE_LIM));
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic row_t cfg_row(cfg_reg_t r, int v);
    row_t t;
    t         = '0;
    t.kind    = ROW_CFG;
    t.reg_sel = r;
    t.cfg_val = CFG_W'(v);
    return t;
  endfunction

  function automatic row_t item_row(logic link, int ry, int rz, row_chk_t chk,
                                    int ex, int ey);
    row_t t;
    t      = '0;
    t.kind = ROW_ITEM;
    t.link = link;
    t.ry   = RATE_W'(ry);
    t.rz   = RATE_W'(rz);
    t.chk  = chk;
    t.mv.x = MOVE_W'(ex);
    t.mv.y = MOVE_W'(ey);
    return t;
  endfunction

  // Idle length: mostly none or short, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 16);
    return $urandom_range(30, 120);
  endfunction

  // Rate around a centre; wide spreads and extremes for the harder modes
  function automatic logic signed [RATE_W-1:0] around(int centre, int spread);
    int v;
    v = centre + int'($urandom_range(0, 2 * spread)) - spread;
    return RATE_W'(clamp(v, -32768, 32767));
  endfunction

  function automatic logic signed [RATE_W-1:0] pick_rate(int centre, int mode);
    if (mode < 45) return around(centre, 300);
    if (mode < 80) return around(centre, 3000);
    if (mode < 95) return RATE_W'($urandom);
    return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
  endfunction

  task automatic flag_error(string msg);
    err_count++;
    if (err_count <= 10)
      $display("%s", msg);
  endtask

  // Hold off until every owed move is out and the block has had time to
  // finish any item that gives no move (a bias divide is the slowest)
  task automatic settle();
    if (input_dirty) begin
      while (move_q.size() != 0)
        @(posedge clk);
      repeat (SETTLE_CYCLES) @(posedge clk);
      input_dirty = 0;
    end
  endtask

  task automatic write_reg(cfg_reg_t r, int v);
    in_ch.valid <= 1'b0;
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_data  <= CFG_W'(v);
    @(posedge clk);
    case (r)
      REG_EMA_ALPHA:   cur_alpha   = ALPHA_W'(v);
      REG_DEAD_BAND:   cur_band    = DB_W'(v);
      REG_MOTION_GAIN: cur_gain    = GAIN_W'(v);
      REG_CAL_COUNT:   cur_cal_len = CC_W'(v);
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one item and hold it until taken; valid stays high on return so a
  // back-to-back item needs no second assignment in the same step
  task automatic send_item(logic link, logic signed [RATE_W-1:0] ry,
                           logic signed [RATE_W-1:0] rz, row_chk_t chk, move_t typed);
    int unsigned gap;
    bit          due;
    move_t       mv;
    if (tx_calm != 0) begin
      tx_calm--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 99) < 2)
        tx_calm = $urandom_range(20, 80);
      gap = idle_len();
    end
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.link_up <= link;
    in_ch.rate_y  <= ry;
    in_ch.rate_z  <= rz;
    do
      @(posedge clk);
    while (!in_ch.ready);
    items_sent++;
    due         = predict_move(link, ry, rz, mv);
    input_dirty = 1;
    case (chk)
      CHK_MODEL: if (due) move_q.push_back(mv);
      CHK_MOVE:  move_q.push_back(typed);
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, calm stretches, and long hold-offs that let
  // moves back up until the block stops taking items
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rx_stall != 0) begin
      rx_stall     <= rx_stall - 1;
      out_ch.ready <= 1'b0;
    end else if (moves_seen >= hold_at) begin
      rx_stall     <= LONG_HOLD;
      hold_at      <= (hold_at == 40) ? 400 : '1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if (rx_calm != 0)
        rx_calm <= rx_calm - 1;
      else if ($urandom_range(0, 99) < 2)
        rx_calm <= $urandom_range(30, 120);
      else
        rx_stall <= idle_len();
    end
  end

  // Check each move taken against the oldest one owed
  always @(posedge clk) begin
    move_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      moves_seen <= moves_seen + 1;
      if (move_q.size() == 0) begin
        flag_error($sformatf("move x=%0d y=%0d with none expected",
                             out_ch.move_x, out_ch.move_y));
      end else begin
        want = move_q.pop_front();
        if (want.x !== out_ch.move_x || want.y !== out_ch.move_y)
          flag_error($sformatf("move mismatch: expected x=%0d y=%0d, got x=%0d y=%0d",
                               want.x, want.y, out_ch.move_x, out_ch.move_y));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned phase, target, in_phase, r, mode;
    int          cy, cz, alpha_v, band_v, gain_v, cal_v;

    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = REG_EMA_ALPHA;
    cfg_data      = '0;
    in_ch.valid   = 1'b0;
    in_ch.link_up = 1'b0;
    in_ch.rate_y  = '0;
    in_ch.rate_z  = '0;

    cur_alpha   = ALPHA_RST;
    cur_band    = DB_RST;
    cur_gain    = GAIN_RST;
    cur_cal_len = CC_RST;
    cal_done    = 1'b0;
    cal_seen    = '0;
    rate_sum_y  = '0;
    rate_sum_z  = '0;
    offset_y    = '0;
    offset_z    = '0;
    ema_y       = '0;
    ema_z       = '0;
    frac_x      = '0;
    frac_y      = '0;

    // Directed rows. With alpha at one, no dead band, a gain of minus one
    // pixel per count and a zero offset, a rate steps the pointer by minus
    // itself, so the early moves can be typed straight in.
    directed_rows = '{
      cfg_row(REG_CAL_COUNT, 1),
      cfg_row(REG_EMA_ALPHA, 256),
      cfg_row(REG_DEAD_BAND, 0),
      cfg_row(REG_MOTION_GAIN, -65536),
      item_row(1'b1, 0, 0, CHK_NONE, 0, 0),                  // sets a zero offset
      item_row(1'b1, 0, 5, CHK_MOVE, -5, 0),
      item_row(1'b1, -3, 0, CHK_MOVE, 0, 3),
      item_row(1'b1, 32767, -32768, CHK_MOVE, 127, -127),    // both accumulators pin
      item_row(1'b1, 0, 0, CHK_NONE, 0, 0),                  // only a fraction left
      item_row(1'b0, 1234, -4321, CHK_NONE, 0, 0),           // link down
      item_row(1'b1, 100, -100, CHK_NONE, 0, 0),             // recalibrate
      item_row(1'b1, 100, -100, CHK_MODEL, 0, 0),
      item_row(1'b1, 101, -101, CHK_MODEL, 0, 0),
      cfg_row(REG_EMA_ALPHA, 511),                           // beyond one
      cfg_row(REG_DEAD_BAND, 8388607),
      cfg_row(REG_MOTION_GAIN, 65535),
      item_row(1'b1, -32768, 32767, CHK_MODEL, 0, 0),        // just clears the band
      item_row(1'b1, 5, 5, CHK_MODEL, 0, 0),
      cfg_row(REG_EMA_ALPHA, 0),                             // filter frozen
      cfg_row(REG_DEAD_BAND, 3354),
      item_row(1'b1, 2000, -2000, CHK_MODEL, 0, 0),
      cfg_row(REG_EMA_ALPHA, 77),
      cfg_row(REG_MOTION_GAIN, 0),
      item_row(1'b1, -700, 900, CHK_MODEL, 0, 0),
      cfg_row(REG_CAL_COUNT, 0),                             // acts as one sample
      item_row(1'b0, -1, -1, CHK_NONE, 0, 0),
      item_row(1'b1, -250, 300, CHK_NONE, 0, 0),
      cfg_row(REG_MOTION_GAIN, -1001),
      item_row(1'b1, 400, -400, CHK_MODEL, 0, 0),
      cfg_row(REG_CAL_COUNT, 10),
      item_row(1'b0, 0, 0, CHK_NONE, 0, 0),
      item_row(1'b1, 17, -9, CHK_MODEL, 0, 0),
      item_row(1'b1, -32768, 32767, CHK_MODEL, 0, 0),
      item_row(1'b1, 32767, -32768, CHK_MODEL, 0, 0),
      item_row(1'b1, -5, 3, CHK_MODEL, 0, 0),
      cfg_row(REG_CAL_COUNT, 2),                             // lowered part way
      item_row(1'b1, 60, -40, CHK_MODEL, 0, 0),              // closes on five
      item_row(1'b1, 900, -1200, CHK_MODEL, 0, 0),
      item_row(1'b1, -3000, 2500, CHK_MODEL, 0, 0)
    };

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG)
        write_reg(directed_rows[i].reg_sel, int'(directed_rows[i].cfg_val));
      else
        send_item(directed_rows[i].link, directed_rows[i].ry, directed_rows[i].rz,
                  directed_rows[i].chk, directed_rows[i].mv);
    end

    // Random phases: new settings, usually a link drop, a calibration run
    // about a random centre, then mostly filtered items near that centre.
    // Phase two calibrates over the full depth, with the count set past it.
    phase = 0;
    while (items_sent < TOTAL_ITEMS) begin
      r       = $urandom_range(0, 9);
      alpha_v = (r == 0) ? 0 : (r == 1) ? 256 :
                (r == 2) ? int'($urandom_range(257, 511)) : int'($urandom_range(8, 255));
      r       = $urandom_range(0, 9);
      band_v  = (r == 0) ? 0 : (r == 1) ? 8388607 :
                (r == 2) ? int'($urandom_range(0, 8388607)) : int'($urandom_range(0, 40000));
      r       = $urandom_range(0, 9);
      gain_v  = (r == 0) ? -65536 : (r == 1) ? 65535 : (r == 2) ? 0 :
                (r == 3) ? int'($urandom_range(0, 131071)) - 65536 :
                ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(200, 4000));
      r       = $urandom_range(0, 9);
      cal_v   = (phase == 2) ? 2047 : (r == 0) ? 0 :
                (r == 1) ? int'($urandom_range(9, 40)) : int'($urandom_range(1, 8));
      write_reg(REG_EMA_ALPHA, alpha_v);
      write_reg(REG_DEAD_BAND, band_v);
      write_reg(REG_MOTION_GAIN, gain_v);
      write_reg(REG_CAL_COUNT, cal_v);

      if (phase == 2 || $urandom_range(0, 3) != 0)
        send_item(1'b0, RATE_W'($urandom), RATE_W'($urandom), CHK_MODEL, '0);

      cy       = int'($urandom_range(0, 3000)) - 1500;
      cz       = int'($urandom_range(0, 3000)) - 1500;
      target   = $urandom_range(15, 60);
      in_phase = 0;
      while (in_phase < target) begin
        r = $urandom_range(0, 99);
        if (!cal_done) begin
          // drop the link now and then, but never on a long calibration run
          if (r < 2 && cur_cal_len <= 40)
            send_item(1'b0, RATE_W'($urandom), RATE_W'($urandom), CHK_MODEL, '0);
          else if (r < 10)
            send_item(1'b1, RATE_W'($urandom), RATE_W'($urandom), CHK_MODEL, '0);
          else
            send_item(1'b1, around(cy, 30), around(cz, 30), CHK_MODEL, '0);
        end else if (r < 3 && cur_cal_len <= 40) begin
          send_item(1'b0, RATE_W'($urandom), RATE_W'($urandom), CHK_MODEL, '0);
        end else begin
          mode = $urandom_range(0, 99);
          send_item(1'b1, pick_rate(cy, mode), pick_rate(cz, mode), CHK_MODEL, '0);
          in_phase++;
        end
      end
      phase++;
    end

    // Drain: wait for every owed move, then give the block time to show
    // anything it should not
    in_ch.valid <= 1'b0;
    while (move_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (move_q.size() != 0)
      flag_error($sformatf("%0d expected moves never arrived", move_q.size()));
    if (err_count == 0)
      $display("gyro_to_pointer_motion_tb: done, clean");
    else
      $display("gyro_to_pointer_motion_tb: done, errors");
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #(TIMEOUT_NS);
    $display("gyro_to_pointer_motion_tb: done, errors");
    $finish;
  end

endmodule
